// ===== hw/rtl/fdr_pkg.sv =====
// ----------------------------------------------------------------------------
// fdr_pkg
// Shared widths, constants and types of the Fresnel reflectance unit.
// ----------------------------------------------------------------------------
package fdr_pkg;

    localparam int unsigned VEC_W       = 16;
    localparam int unsigned IDX_W       = 15;
    localparam int unsigned OUT_W       = 16;
    localparam int unsigned COS_W       = 32;
    localparam int unsigned FRAC        = 30;
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
    localparam logic [30:0] TIR_LIM_P1 = 31'd1073740751;
    localparam logic [15:0] FULL_Q15   = 16'h8000;

    typedef struct packed {
        logic                    bad;
        logic signed [COS_W-1:0] cosa;
        logic [IDX_W-1:0]        n1;
        logic [IDX_W-1:0]        n2;
    } t_side;

endpackage

// ===== hw/rtl/fdr_item_if.sv =====
// ----------------------------------------------------------------------------
// fdr_item_if
// Input channel: normal, incident direction and refractive indices.
// ----------------------------------------------------------------------------
interface fdr_item_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [fdr_pkg::VEC_W-1:0]     normal_x;
    logic signed [fdr_pkg::VEC_W-1:0]     normal_y;
    logic signed [fdr_pkg::VEC_W-1:0]     normal_z;
    logic signed [fdr_pkg::VEC_W-1:0]     dir_x;
    logic signed [fdr_pkg::VEC_W-1:0]     dir_y;
    logic signed [fdr_pkg::VEC_W-1:0]     dir_z;
    logic [fdr_pkg::IDX_W-1:0]            index_in;
    logic [fdr_pkg::IDX_W-1:0]            index_out;

    modport source (
        output valid, normal_x, normal_y, normal_z, dir_x, dir_y, dir_z,
               index_in, index_out,
        input  ready
    );
    modport sink (
        input  valid, normal_x, normal_y, normal_z, dir_x, dir_y, dir_z,
               index_in, index_out,
        output ready
    );
endinterface

// ===== hw/rtl/fdr_res_if.sv =====
// ----------------------------------------------------------------------------
// fdr_res_if
// Result channel: reflectance and total reflection flag.
// ----------------------------------------------------------------------------
interface fdr_res_if;
    logic                      valid;
    logic                      ready;
    logic [fdr_pkg::OUT_W-1:0] reflectance;
    logic                      total_reflection;

    modport source (output valid, reflectance, total_reflection, input ready);
    modport sink   (input valid, reflectance, total_reflection, output ready);
endinterface

// ===== hw/rtl/fdr_front.sv =====
// ----------------------------------------------------------------------------
// fdr_front
// Accept transactions, form the clamped cosine and flag a zero outgoing index.
// ----------------------------------------------------------------------------
module fdr_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    fdr_item_if.sink        i_item,
    output logic            o_wr_vld,
    input  logic            i_wr_rdy,
    output fdr_pkg::t_side  o_wr_data
);
    localparam logic signed [33:0] LIM = $signed({3'b000, fdr_pkg::ONE_Q30});

    logic                             r_vld;
    logic signed [31:0]               r_px;
    logic signed [31:0]               r_py;
    logic signed [31:0]               r_pz;
    logic [fdr_pkg::IDX_W-1:0]        r_n1;
    logic [fdr_pkg::IDX_W-1:0]        r_n2;
    logic                             adv;
    logic signed [33:0]               c_neg;
    logic signed [fdr_pkg::COS_W-1:0] c_cosa;

    assign adv          = !r_vld || i_wr_rdy;
    assign i_item.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (adv) begin
            r_vld <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_item.valid) begin
            r_px <= i_item.normal_x * i_item.dir_x;
            r_py <= i_item.normal_y * i_item.dir_y;
            r_pz <= i_item.normal_z * i_item.dir_z;
            r_n1 <= i_item.index_in;
            r_n2 <= i_item.index_out;
        end
    end

    always_comb begin
        c_neg = -(34'(r_px) + 34'(r_py) + 34'(r_pz));
        if (c_neg > LIM) begin
            c_cosa = LIM[fdr_pkg::COS_W-1:0];
        end else if (c_neg < -LIM) begin
            c_cosa = 32'(-LIM);
        end else begin
            c_cosa = c_neg[fdr_pkg::COS_W-1:0];
        end
    end

    assign o_wr_vld       = r_vld;
    assign o_wr_data.bad  = (r_n2 == '0);
    assign o_wr_data.cosa = c_cosa;
    assign o_wr_data.n1   = r_n1;
    assign o_wr_data.n2   = r_n2;

endmodule

// ===== hw/rtl/fdr_queue.sv =====
// ----------------------------------------------------------------------------
// fdr_queue
// Short queue between front and back.
// ----------------------------------------------------------------------------
module fdr_queue #(
    parameter int unsigned DEPTH = fdr_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr_vld,
    output logic            o_wr_rdy,
    input  fdr_pkg::t_side  i_wr_data,
    output logic            o_rd_vld,
    input  logic            i_rd_rdy,
    output fdr_pkg::t_side  o_rd_data
);
    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    fdr_pkg::t_side r_mem [DEPTH];
    logic [AW-1:0]  r_wp;
    logic [AW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;
    logic           push;
    logic           pop;

    assign o_wr_rdy  = (r_cnt != CW'(DEPTH));
    assign o_rd_vld  = (r_cnt != '0);
    assign o_rd_data = r_mem[r_rp];
    assign push      = i_wr_vld && o_wr_rdy;
    assign pop       = o_rd_vld && i_rd_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_wr_data;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("queue count above depth");

    a_cnt_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_cnt == CW'($past(r_cnt) + 1'b1)))
        else $error("queue count lost a push");

    a_cnt_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !push) |=> (r_cnt == CW'($past(r_cnt) - 1'b1)))
        else $error("queue count lost a pop");

endmodule

// ===== hw/rtl/fdr_sqrt_pipe.sv =====
// ----------------------------------------------------------------------------
// fdr_sqrt_pipe
// Pipelined floor square root, one result bit per stage, with sideband.
// ----------------------------------------------------------------------------
module fdr_sqrt_pipe #(
    parameter int unsigned IW = 62,
    parameter int unsigned SW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  logic [IW-1:0]   i_val,
    input  logic [SW-1:0]   i_side,
    output logic            o_vld,
    output logic [IW/2-1:0] o_root,
    output logic [SW-1:0]   o_side
);
    localparam int unsigned NS = IW / 2;

    logic          r_vld  [NS];
    logic [IW-1:0] r_v    [NS];
    logic [IW-1:0] r_r    [NS];
    logic [SW-1:0] r_side [NS];
    logic [IW-1:0] v_in   [NS];
    logic [IW-1:0] r_in   [NS];
    logic [IW-1:0] n_v    [NS];
    logic [IW-1:0] n_r    [NS];

    always_comb begin
        logic [IW-1:0] t;
        logic [IW-1:0] bit_k;
        v_in[0] = i_val;
        r_in[0] = '0;
        for (int k = 1; k < NS; k++) begin
            v_in[k] = r_v[k-1];
            r_in[k] = r_r[k-1];
        end
        for (int k = 0; k < NS; k++) begin
            bit_k = IW'(1) << (IW - 2 - 2 * k);
            t     = r_in[k] + bit_k;
            if (v_in[k] >= t) begin
                n_v[k] = v_in[k] - t;
                n_r[k] = (r_in[k] >> 1) + bit_k;
            end else begin
                n_v[k] = v_in[k];
                n_r[k] = r_in[k] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int k = 1; k < NS; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 1; k < NS; k++) begin
                r_side[k] <= r_side[k-1];
            end
            for (int k = 0; k < NS; k++) begin
                r_v[k] <= n_v[k];
                r_r[k] <= n_r[k];
            end
        end
    end

    assign o_vld  = r_vld[NS-1];
    assign o_root = r_r[NS-1][NS-1:0];
    assign o_side = r_side[NS-1];

endmodule

// ===== hw/rtl/fdr_div_pipe.sv =====
// ----------------------------------------------------------------------------
// fdr_div_pipe
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module fdr_div_pipe #(
    parameter int unsigned NW = 46,
    parameter int unsigned DW = 15,
    parameter int unsigned QW = 30,
    parameter int unsigned SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_vld,
    output logic [QW-1:0] o_quo,
    output logic [SW-1:0] o_side
);
    logic          r_vld  [QW];
    logic [DW-1:0] r_rem  [QW];
    logic [QW-1:0] r_lo   [QW];
    logic [QW-1:0] r_q    [QW];
    logic [DW-1:0] r_d    [QW];
    logic [SW-1:0] r_side [QW];
    logic [DW-1:0] rem_in [QW];
    logic [QW-1:0] lo_in  [QW];
    logic [QW-1:0] q_in   [QW];
    logic [DW-1:0] d_in   [QW];
    logic [DW-1:0] n_rem  [QW];
    logic [QW-1:0] n_lo   [QW];
    logic [QW-1:0] n_q    [QW];

    always_comb begin
        logic [DW:0] x;
        logic        qb;
        rem_in[0] = DW'(i_num >> QW);
        lo_in[0]  = i_num[QW-1:0];
        q_in[0]   = '0;
        d_in[0]   = i_den;
        for (int k = 1; k < QW; k++) begin
            rem_in[k] = r_rem[k-1];
            lo_in[k]  = r_lo[k-1];
            q_in[k]   = r_q[k-1];
            d_in[k]   = r_d[k-1];
        end
        for (int k = 0; k < QW; k++) begin
            x = {rem_in[k], lo_in[k][QW-1]};
            if (x >= {1'b0, d_in[k]}) begin
                n_rem[k] = DW'(x - {1'b0, d_in[k]});
                qb       = 1'b1;
            end else begin
                n_rem[k] = DW'(x);
                qb       = 1'b0;
            end
            n_q[k]  = {q_in[k][QW-2:0], qb};
            n_lo[k] = lo_in[k] << 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QW; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int k = 1; k < QW; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            for (int k = 1; k < QW; k++) begin
                r_side[k] <= r_side[k-1];
            end
            for (int k = 0; k < QW; k++) begin
                r_rem[k] <= n_rem[k];
                r_lo[k]  <= n_lo[k];
                r_q[k]   <= n_q[k];
                r_d[k]   <= d_in[k];
            end
        end
    end

    assign o_vld  = r_vld[QW-1];
    assign o_quo  = r_q[QW-1];
    assign o_side = r_side[QW-1];

endmodule

// ===== hw/rtl/fdr_back.sv =====
// ----------------------------------------------------------------------------
// fdr_back
// Evaluate refraction angle and s/p amplitude ratios, hold the result.
// ----------------------------------------------------------------------------
module fdr_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rd_vld,
    output logic            o_rd_rdy,
    input  fdr_pkg::t_side  i_rd_data,
    fdr_res_if.source       o_res
);
    localparam int unsigned SW = $bits(fdr_pkg::t_side);

    logic                  adv;

    logic                  r_s1_vld;
    fdr_pkg::t_side        r_s1_side;
    logic [61:0]           r_s1_sq;
    logic [30:0]           c_ca1;

    logic                  r_s2_vld;
    fdr_pkg::t_side        r_s2_side;
    logic [61:0]           r_s2_x;

    logic                  c_q1_vld;
    logic [30:0]           c_sina;
    fdr_pkg::t_side        c_q1_side;

    logic                  r_s3_vld;
    fdr_pkg::t_side        r_s3_side;
    logic [45:0]           r_s3_p;

    logic                  c_tir;
    logic                  r_s4_vld;
    fdr_pkg::t_side        r_s4_side;
    logic [45:0]           r_s4_p;

    logic                  c_d1_vld;
    logic [29:0]           c_sinb;
    fdr_pkg::t_side        c_d1_side;

    logic                  r_s5_vld;
    fdr_pkg::t_side        r_s5_side;
    logic [59:0]           r_s5_sq;

    logic                  r_s6_vld;
    fdr_pkg::t_side        r_s6_side;
    logic [61:0]           r_s6_x;

    logic                  c_q2_vld;
    logic [30:0]           c_cosb;
    fdr_pkg::t_side        c_q2_side;

    logic [30:0]           c_ca7;
    logic [45:0]           c_m_a1;
    logic [45:0]           c_m_a2;
    logic [45:0]           c_m_b1;
    logic [45:0]           c_m_b2;
    logic                  r_s7_vld;
    logic                  r_s7_bad;
    logic signed [33:0]    r_s7_a1;
    logic signed [33:0]    r_s7_a2;
    logic [31:0]           r_s7_b1;
    logic [31:0]           r_s7_b2;

    logic signed [34:0]    c_ns;
    logic signed [34:0]    c_ds;
    logic signed [34:0]    c_np;
    logic signed [34:0]    c_dp;
    logic [33:0]           c_ans;
    logic [33:0]           c_ads;
    logic [33:0]           c_anp;
    logic [33:0]           c_adp;
    logic                  r_s8_vld;
    logic                  r_s8_bs;
    logic                  r_s8_bp;
    logic [33:0]           r_s8_ans;
    logic [33:0]           r_s8_ads;
    logic [33:0]           r_s8_anp;
    logic [33:0]           r_s8_adp;

    logic                  c_rs_vld;
    logic                  c_rp_vld;
    logic [30:0]           c_rs_q;
    logic [30:0]           c_rp_q;
    logic                  c_rs_bad;
    logic                  c_rp_bad;

    logic                  r_s9_vld;
    logic                  r_s9_bad;
    logic [31:0]           r_s9_rs2;
    logic [31:0]           r_s9_rp2;

    logic [32:0]           c_sum;
    logic [18:0]           c_rnd;
    logic                  r_out_vld;
    logic [15:0]           r_out_refl;
    logic                  r_out_tr;

    assign adv      = !r_out_vld || o_res.ready;
    assign o_rd_rdy = adv;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_s5_vld  <= 1'b0;
            r_s6_vld  <= 1'b0;
            r_s7_vld  <= 1'b0;
            r_s8_vld  <= 1'b0;
            r_s9_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_s1_vld  <= i_rd_vld;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= c_q1_vld;
            r_s4_vld  <= r_s3_vld;
            r_s5_vld  <= c_d1_vld;
            r_s6_vld  <= r_s5_vld;
            r_s7_vld  <= c_q2_vld;
            r_s8_vld  <= r_s7_vld;
            r_s9_vld  <= c_rs_vld && c_rp_vld;
            r_out_vld <= r_s9_vld;
        end
    end

    // cos^2 of incidence, then 1 - cos^2 scaled for the root
    assign c_ca1 = i_rd_data.cosa[31] ? 31'(-i_rd_data.cosa) : i_rd_data.cosa[30:0];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_side <= i_rd_data;
            r_s1_sq   <= 62'(c_ca1) * 62'(c_ca1);
            r_s2_side <= r_s1_side;
            r_s2_x    <= 62'(fdr_pkg::ONE_Q30 - 31'(r_s1_sq >> fdr_pkg::FRAC)) << fdr_pkg::FRAC;
        end
    end

    fdr_sqrt_pipe #(
        .IW (62),
        .SW (SW)
    ) u_sqrt_sina (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (r_s2_vld),
        .i_val   (r_s2_x),
        .i_side  (r_s2_side),
        .o_vld   (c_q1_vld),
        .o_root  (c_sina),
        .o_side  (c_q1_side)
    );

    // sinB numerator and total reflection check
    assign c_tir = r_s3_p >= (46'(r_s3_side.n2) * 46'(fdr_pkg::TIR_LIM_P1));

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s3_side <= c_q1_side;
            r_s3_p    <= 46'(c_q1_side.n1) * 46'(c_sina);
            r_s4_side <= '{bad:  r_s3_side.bad || c_tir,
                           cosa: r_s3_side.cosa,
                           n1:   r_s3_side.n1,
                           n2:   r_s3_side.n2};
            r_s4_p    <= r_s3_p;
        end
    end

    fdr_div_pipe #(
        .NW (46),
        .DW (fdr_pkg::IDX_W),
        .QW (fdr_pkg::FRAC),
        .SW (SW)
    ) u_div_sinb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (r_s4_vld),
        .i_num   (r_s4_p),
        .i_den   (r_s4_side.n2),
        .i_side  (r_s4_side),
        .o_vld   (c_d1_vld),
        .o_quo   (c_sinb),
        .o_side  (c_d1_side)
    );

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s5_side <= c_d1_side;
            r_s5_sq   <= 60'(c_sinb) * 60'(c_sinb);
            r_s6_side <= r_s5_side;
            r_s6_x    <= 62'(fdr_pkg::ONE_Q30 - 31'(r_s5_sq >> fdr_pkg::FRAC)) << fdr_pkg::FRAC;
        end
    end

    fdr_sqrt_pipe #(
        .IW (62),
        .SW (SW)
    ) u_sqrt_cosb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (r_s6_vld),
        .i_val   (r_s6_x),
        .i_side  (r_s6_side),
        .o_vld   (c_q2_vld),
        .o_root  (c_cosb),
        .o_side  (c_q2_side)
    );

    // index-scaled cosines, truncated toward zero
    assign c_ca7  = c_q2_side.cosa[31] ? 31'(-c_q2_side.cosa) : c_q2_side.cosa[30:0];
    assign c_m_a1 = 46'(c_q2_side.n1) * 46'(c_ca7);
    assign c_m_a2 = 46'(c_q2_side.n2) * 46'(c_ca7);
    assign c_m_b1 = 46'(c_q2_side.n1) * 46'(c_cosb);
    assign c_m_b2 = 46'(c_q2_side.n2) * 46'(c_cosb);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s7_bad <= c_q2_side.bad;
            r_s7_a1  <= c_q2_side.cosa[31] ? -$signed({2'b00, c_m_a1[44:13]})
                                           : $signed({2'b00, c_m_a1[44:13]});
            r_s7_a2  <= c_q2_side.cosa[31] ? -$signed({2'b00, c_m_a2[44:13]})
                                           : $signed({2'b00, c_m_a2[44:13]});
            r_s7_b1  <= c_m_b1[44:13];
            r_s7_b2  <= c_m_b2[44:13];
        end
    end

    // ratio terms and their magnitudes
    always_comb begin
        c_ns  = 35'(r_s7_a1) - $signed({3'b000, r_s7_b2});
        c_ds  = 35'(r_s7_a1) + $signed({3'b000, r_s7_b2});
        c_np  = 35'(r_s7_a2) - $signed({3'b000, r_s7_b1});
        c_dp  = 35'(r_s7_a2) + $signed({3'b000, r_s7_b1});
        c_ans = c_ns[34] ? 34'(-c_ns) : c_ns[33:0];
        c_ads = c_ds[34] ? 34'(-c_ds) : c_ds[33:0];
        c_anp = c_np[34] ? 34'(-c_np) : c_np[33:0];
        c_adp = c_dp[34] ? 34'(-c_dp) : c_dp[33:0];
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s8_bs  <= r_s7_bad || (c_ads == '0) || ({1'b0, c_ans} > {c_ads, 1'b0});
            r_s8_bp  <= (c_adp == '0) || ({1'b0, c_anp} > {c_adp, 1'b0});
            r_s8_ans <= c_ans;
            r_s8_ads <= c_ads;
            r_s8_anp <= c_anp;
            r_s8_adp <= c_adp;
        end
    end

    fdr_div_pipe #(
        .NW (63),
        .DW (34),
        .QW (31),
        .SW (1)
    ) u_div_rs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (r_s8_vld),
        .i_num   ({r_s8_ans, 29'd0}),
        .i_den   (r_s8_ads),
        .i_side  (r_s8_bs),
        .o_vld   (c_rs_vld),
        .o_quo   (c_rs_q),
        .o_side  (c_rs_bad)
    );

    fdr_div_pipe #(
        .NW (63),
        .DW (34),
        .QW (31),
        .SW (1)
    ) u_div_rp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (r_s8_vld),
        .i_num   ({r_s8_anp, 29'd0}),
        .i_den   (r_s8_adp),
        .i_side  (r_s8_bp),
        .o_vld   (c_rp_vld),
        .o_quo   (c_rp_q),
        .o_side  (c_rp_bad)
    );

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s9_bad <= c_rs_bad || c_rp_bad;
            r_s9_rs2 <= 32'((62'(c_rs_q) * 62'(c_rs_q)) >> 29);
            r_s9_rp2 <= 32'((62'(c_rp_q) * 62'(c_rp_q)) >> 29);
        end
    end

    // mean, round half up, saturate
    assign c_sum = 33'(r_s9_rs2) + 33'(r_s9_rp2);
    assign c_rnd = 19'((33'(c_sum[32:1]) + 33'd8192) >> 14);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_s9_bad || (c_rnd > 19'(fdr_pkg::FULL_Q15))) begin
                r_out_refl <= fdr_pkg::FULL_Q15;
                r_out_tr   <= 1'b1;
            end else begin
                r_out_refl <= c_rnd[15:0];
                r_out_tr   <= 1'b0;
            end
        end
    end

    assign o_res.valid            = r_out_vld;
    assign o_res.reflectance      = r_out_refl;
    assign o_res.total_reflection = r_out_tr;

    a_tr_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.total_reflection) |-> (o_res.reflectance == fdr_pkg::FULL_Q15))
        else $error("total reflection without full reflectance");

    a_refl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.reflectance <= fdr_pkg::FULL_Q15))
        else $error("reflectance above one");

    a_div_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_rs_vld == c_rp_vld)
        else $error("ratio dividers out of step");

endmodule

// ===== hw/rtl/fresnel_dielectric_reflectance_unit.sv =====
// ----------------------------------------------------------------------------
// fresnel_dielectric_reflectance_unit
// Unpolarized Fresnel reflectance at a dielectric boundary, fixed point.
//
//   channel  dir  handshake     payload
//   i_item   in   valid/ready   normal_x/y/z, dir_x/y/z, index_in, index_out
//   o_res    out  valid/ready   reflectance, total_reflection
//
// One transaction per cycle sustained while o_res is not stalled.
// The back end holds the two square root pipelines and three dividers,
// each one result bit per stage.
// Synchronous active-low reset clears all valid state; no clearing pass.
// Front and back stall independently across the queue; an output stall
// holds the whole back pipeline.
// ----------------------------------------------------------------------------
module fresnel_dielectric_reflectance_unit #(
    parameter int unsigned P_QUEUE_DEPTH = fdr_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fdr_item_if.sink    i_item,
    fdr_res_if.source   o_res
);
    logic           wr_vld;
    logic           wr_rdy;
    fdr_pkg::t_side wr_data;
    logic           rd_vld;
    logic           rd_rdy;
    fdr_pkg::t_side rd_data;

    fdr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .o_wr_vld  (wr_vld),
        .i_wr_rdy  (wr_rdy),
        .o_wr_data (wr_data)
    );

    fdr_queue #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_vld  (wr_vld),
        .o_wr_rdy  (wr_rdy),
        .i_wr_data (wr_data),
        .o_rd_vld  (rd_vld),
        .i_rd_rdy  (rd_rdy),
        .o_rd_data (rd_data)
    );

    fdr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_vld  (rd_vld),
        .o_rd_rdy  (rd_rdy),
        .i_rd_data (rd_data),
        .o_res     (o_res)
    );

endmodule
